>>> hdl/crxd_pkg.sv
// Shared types and constants of the CANopen servo receive decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package crxd_pkg;

  localparam int SlotCount = 3;

  localparam logic [10:0] Tpdo1Base   = 11'h180;
  localparam logic [10:0] SdoRespBase = 11'h580;
  localparam logic [7:0]  SdoUp4Byte  = 8'h43;
  localparam logic [7:0]  SdoUp2Byte  = 8'h4B;
  localparam logic [15:0] ObjSpeed    = 16'h6069;
  localparam logic [15:0] ObjPosition = 16'h6063;
  localparam logic [15:0] ObjError    = 16'h603F;
  localparam logic [15:0] ObjStatus   = 16'h6041;
  localparam logic [3:0]  LenFull     = 4'd8;
  localparam logic [3:0]  LenShort    = 4'd6;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegSlot0Node   = 3'd0,
    RegSlot1Node   = 3'd1,
    RegSlot2Node   = 3'd2,
    RegSlot0Layout = 3'd3,
    RegSlot1Layout = 3'd4,
    RegSlot2Layout = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KindStatus   = 2'd0,
    KindSpeed    = 2'd1,
    KindPosition = 2'd2,
    KindError    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [10:0] frame_ident;
    logic [63:0] frame_payload;
    logic [3:0]  frame_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         target_slot;
    kind_t              update_kind;
    logic signed [31:0] update_value;
    logic               last_update;
  } out_item_t;

  typedef struct packed {
    logic [SlotCount-1:0][6:0] node_id;
    logic [SlotCount-1:0]      layout;
  } cfg_t;

  // after slot match
  typedef struct packed {
    logic [1:0]  slot;
    logic        layout;
    logic [63:0] payload;
    logic [3:0]  length;
  } match_t;

  // up to three decoded updates of one frame
  typedef struct packed {
    logic [1:0]             slot;
    logic [1:0]             count;
    kind_t [2:0]            kind;
    logic [2:0][31:0]       value;
  } decoded_t;

endpackage

`default_nettype wire

>>> hdl/crxd_match.sv
// Stage one: identifier match against the servo slots.
// Depends on crxd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crxd_match import crxd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_ready,
  output logic          m_valid,
  output match_t        m_data,
  input  wire logic     m_ready
);

  logic   m_valid_r, m_valid_nxt;
  match_t m_data_r, m_data_nxt;
  logic   found;
  logic [1:0] slot;
  logic   load;

  // lowest slot index wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (in_item.frame_ident == Tpdo1Base + 11'(cfg.node_id[i]) ||
          in_item.frame_ident == SdoRespBase + 11'(cfg.node_id[i])) begin
        found = 1'b1;
        slot  = 2'(i);
      end
    end
  end

  assign load     = !m_valid_r || m_ready;
  assign in_ready = load;

  always_comb begin
    m_valid_nxt = load ? (in_valid && found) : m_valid_r;
    m_data_nxt.slot    = slot;
    m_data_nxt.layout  = cfg.layout[slot];
    m_data_nxt.payload = in_item.frame_payload;
    m_data_nxt.length  = in_item.frame_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      m_data_r <= m_data_nxt;
    end
  end

  assign m_valid = m_valid_r;
  assign m_data  = m_data_r;

endmodule

`default_nettype wire

>>> hdl/crxd_decode.sv
// Stage two: payload decode by layout and length into up to three updates.
// Depends on crxd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crxd_decode import crxd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   m_valid,
  input  wire match_t m_data,
  output logic        m_ready,
  output logic        d_valid,
  output decoded_t    d_data,
  input  wire logic   d_ready
);

  logic     d_valid_r, d_valid_nxt;
  decoded_t d_data_r, d_data_nxt;
  logic     load;
  logic [63:0] p;
  logic [7:0]  cmd;
  logic [15:0] obj;
  logic        sdo_hit;
  kind_t       sdo_kind;
  logic [31:0] sdo_val;
  logic        is_sdo_cmd;

  assign p   = m_data.payload;
  assign cmd = p[7:0];
  assign obj = p[23:8];
  assign is_sdo_cmd = (cmd == SdoUp4Byte) || (cmd == SdoUp2Byte);

  // SDO upload response
  always_comb begin
    sdo_hit  = 1'b0;
    sdo_kind = KindStatus;
    sdo_val  = {16'h0000, p[47:32]};
    if (cmd == SdoUp4Byte) begin
      if (obj == ObjSpeed) begin
        sdo_hit = 1'b1; sdo_kind = KindSpeed; sdo_val = p[63:32];
      end else if (obj == ObjPosition) begin
        sdo_hit = 1'b1; sdo_kind = KindPosition; sdo_val = p[63:32];
      end else if (obj == ObjError) begin
        sdo_hit = 1'b1; sdo_kind = KindError;
      end
    end else if (cmd == SdoUp2Byte) begin
      if (obj == ObjStatus) begin
        sdo_hit = 1'b1; sdo_kind = KindStatus;
      end else if (obj == ObjError) begin
        sdo_hit = 1'b1; sdo_kind = KindError;
      end
    end
  end

  always_comb begin
    d_data_nxt.slot    = m_data.slot;
    d_data_nxt.count   = 2'd0;
    d_data_nxt.kind[0] = KindStatus;
    d_data_nxt.kind[1] = KindSpeed;
    d_data_nxt.kind[2] = KindPosition;
    d_data_nxt.value   = '0;
    if (m_data.length == LenFull && (!m_data.layout || is_sdo_cmd)) begin
      d_data_nxt.count    = sdo_hit ? 2'd1 : 2'd0;
      d_data_nxt.kind[0]  = sdo_kind;
      d_data_nxt.value[0] = sdo_val;
    end else if (m_data.length == LenFull) begin
      // slide position TPDO: status, 16-bit speed, position
      d_data_nxt.count    = 2'd3;
      d_data_nxt.value[0] = {16'h0000, p[15:0]};
      d_data_nxt.value[1] = {{16{p[31]}}, p[31:16]};
      d_data_nxt.value[2] = p[63:32];
    end else if (m_data.length == LenShort && !m_data.layout) begin
      // drive velocity TPDO: status, 32-bit speed
      d_data_nxt.count    = 2'd2;
      d_data_nxt.value[0] = {16'h0000, p[15:0]};
      d_data_nxt.value[1] = p[47:16];
    end
  end

  assign load    = !d_valid_r || d_ready;
  assign m_ready = load;

  assign d_valid_nxt = load ? (m_valid && d_data_nxt.count != 2'd0) : d_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && m_valid) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign d_valid = d_valid_r;
  assign d_data  = d_data_r;

endmodule

`default_nettype wire

>>> hdl/crxd_emit.sv
// Stage three: serializes the decoded updates into the output register.
// Depends on crxd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crxd_emit import crxd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     d_valid,
  input  wire decoded_t d_data,
  output logic          d_ready,
  output logic          out_valid,
  output out_item_t     out_item,
  input  wire logic     out_ready
);

  logic      ent_valid_r, ent_valid_nxt;
  decoded_t  ent_r;
  logic [1:0] idx_r, idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      out_load, fire, is_last, take;

  assign out_load = !out_valid_r || out_ready;
  assign fire     = ent_valid_r && out_load;
  assign is_last  = (idx_r == ent_r.count - 2'd1);
  assign d_ready  = !ent_valid_r || (fire && is_last);
  assign take     = d_valid && d_ready;

  always_comb begin
    out_item_nxt.target_slot = ent_r.slot;
    out_item_nxt.last_update = is_last;
    unique case (idx_r)
      2'd0: begin
        out_item_nxt.update_kind  = ent_r.kind[0];
        out_item_nxt.update_value = ent_r.value[0];
      end
      2'd1: begin
        out_item_nxt.update_kind  = ent_r.kind[1];
        out_item_nxt.update_value = ent_r.value[1];
      end
      default: begin
        out_item_nxt.update_kind  = ent_r.kind[2];
        out_item_nxt.update_value = ent_r.value[2];
      end
    endcase
  end

  always_comb begin
    ent_valid_nxt = ent_valid_r;
    idx_nxt       = idx_r;
    if (take) begin
      ent_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (fire && is_last) begin
      ent_valid_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
    out_valid_nxt = out_load ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      ent_valid_r <= ent_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= d_data;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> hdl/canopen_servo_rx_frame_decoder_top.sv
// CANopen servo receive decoder: takes one received standard CAN frame per
// transaction, matches its identifier against three servo slots (TPDO1 at
// 0x180 + node id, SDO response at 0x580 + node id, lowest slot first) and
// emits zero to three update transactions (status, speed, position or error
// code) with last_update marking the final one of a frame. The pipeline is
// match register, decode register, an emitter entry and the output register.
// The match register loads at the accepting edge; the first update of a
// frame then passes the decode register and the emitter entry to the output
// register. A new frame can be accepted every cycle unless stalled; the
// emitter sends one update per cycle while out_ready allows, and a frame
// holds the emitter until its last update is sent. Frames that match no
// slot or no decoding rule are dropped inside the pipe and produce nothing.
// The user must write configuration through cfg_we/cfg_index/cfg_data, one
// register per cycle, only while the block is idle (not enforced). Indexes
// six and seven are ignored. Depends on crxd_pkg and the crxd_* stages.
`timescale 1ns / 1ps
`default_nettype none

module canopen_servo_rx_frame_decoder_top import crxd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // frame input
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  // update output
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item,
  // configuration writes
  input  wire logic      cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  logic     m_valid, m_ready;
  match_t   m_data;
  logic     d_valid, d_ready;
  decoded_t d_data;

  // Configuration registers; node ids default to 1, 2, 3 and only slot two
  // uses the slide position layout.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        RegSlot0Node:   cfg_nxt.node_id[0] = cfg_data;
        RegSlot1Node:   cfg_nxt.node_id[1] = cfg_data;
        RegSlot2Node:   cfg_nxt.node_id[2] = cfg_data;
        RegSlot0Layout: cfg_nxt.layout[0]  = cfg_data[0];
        RegSlot1Layout: cfg_nxt.layout[1]  = cfg_data[0];
        RegSlot2Layout: cfg_nxt.layout[2]  = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id <= {7'd3, 7'd2, 7'd1};
      cfg_r.layout  <= 3'b100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // identifier match
  crxd_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .m_valid  (m_valid),
    .m_data   (m_data),
    .m_ready  (m_ready)
  );

  // payload decode; frames without updates die here
  crxd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_valid (m_valid),
    .m_data  (m_data),
    .m_ready (m_ready),
    .d_valid (d_valid),
    .d_data  (d_data),
    .d_ready (d_ready)
  );

  // one update per cycle into the output register while out_ready allows
  crxd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_valid   (d_valid),
    .d_data    (d_data),
    .d_ready   (d_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

>>> hdl/crxd_checker.sv
// Port-level checks of the servo receive decoder, bound to the top level.
// Depends on crxd_pkg and canopen_servo_rx_frame_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module crxd_checker import crxd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // a stalled update holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("update changed while stalled");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.target_slot <= 2'(SlotCount - 1))
    else $error("update names a slot that does not exist");

  // status and error codes are zero-extended 16-bit values
  a_short_zero_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.update_kind == KindStatus ||
                  out_item.update_kind == KindError)
    |-> out_item.update_value[31:16] == 16'h0000)
    else $error("status or error code not zero-extended");

  // position is always the final update of its frame
  a_position_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.update_kind == KindPosition |-> out_item.last_update)
    else $error("position update not marked last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind canopen_servo_rx_frame_decoder_top crxd_checker u_crxd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

>>> test/crxd_update_checker.sv
// Checker for the CANopen servo receive decoder: watches the frame, update and
// configuration ports, predicts the updates of every accepted frame and
// compares them in order. Depends on crxd_pkg only.
`timescale 1ns / 1ps

module crxd_update_checker import crxd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         mismatch_count,
  output int         updates_pending
);

  logic [6:0] slot_node [SlotCount];
  logic       slot_layout [SlotCount];
  out_item_t  expected_updates [$];

  function automatic out_item_t make_update(input logic [1:0] slot, input kind_t kind,
                                            input logic [31:0] value);
    out_item_t u;
    u              = '0;
    u.target_slot  = slot;
    u.update_kind  = kind;
    u.update_value = value;
    return u;
  endfunction

  // SDO upload response: one update or nothing
  function automatic bit sdo_update(input logic [63:0] p, input logic [1:0] slot,
                                    output out_item_t u);
    u = '0;
    if (p[7:0] == SdoUp4Byte) begin
      if (p[23:8] == ObjSpeed) begin
        u = make_update(slot, KindSpeed, p[63:32]);
        return 1'b1;
      end
      if (p[23:8] == ObjPosition) begin
        u = make_update(slot, KindPosition, p[63:32]);
        return 1'b1;
      end
      if (p[23:8] == ObjError) begin
        u = make_update(slot, KindError, {16'h0000, p[47:32]});
        return 1'b1;
      end
    end else if (p[7:0] == SdoUp2Byte) begin
      if (p[23:8] == ObjStatus) begin
        u = make_update(slot, KindStatus, {16'h0000, p[47:32]});
        return 1'b1;
      end
      if (p[23:8] == ObjError) begin
        u = make_update(slot, KindError, {16'h0000, p[47:32]});
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic decode_frame_updates(input in_item_t f);
    out_item_t   upd [3];
    int          n;
    int          hit;
    logic [1:0]  slot;
    logic [63:0] p;
    n   = 0;
    hit = -1;
    p   = f.frame_payload;
    // lowest slot wins when node ids collide
    for (int i = 0; i < SlotCount; i++) begin
      if (hit < 0 && (f.frame_ident == Tpdo1Base + 11'(slot_node[i]) ||
                      f.frame_ident == SdoRespBase + 11'(slot_node[i])))
        hit = i;
    end
    if (hit < 0) return;
    slot = hit[1:0];
    if (!slot_layout[hit]) begin
      if (f.frame_length == LenFull) begin
        n = sdo_update(p, slot, upd[0]) ? 1 : 0;
      end else if (f.frame_length == LenShort) begin
        upd[0] = make_update(slot, KindStatus, {16'h0000, p[15:0]});
        upd[1] = make_update(slot, KindSpeed, p[47:16]);
        n      = 2;
      end
    end else if (f.frame_length == LenFull) begin
      if (p[7:0] == SdoUp4Byte || p[7:0] == SdoUp2Byte) begin
        n = sdo_update(p, slot, upd[0]) ? 1 : 0;
      end else begin
        upd[0] = make_update(slot, KindStatus, {16'h0000, p[15:0]});
        upd[1] = make_update(slot, KindSpeed, {{16{p[31]}}, p[31:16]});
        upd[2] = make_update(slot, KindPosition, p[63:32]);
        n      = 3;
      end
    end
    for (int k = 0; k < n; k++) begin
      upd[k].last_update = (k == n - 1);
      expected_updates.push_back(upd[k]);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      slot_node[0]   = 7'd1;
      slot_node[1]   = 7'd2;
      slot_node[2]   = 7'd3;
      slot_layout[0] = 1'b0;
      slot_layout[1] = 1'b0;
      slot_layout[2] = 1'b1;
      expected_updates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegSlot0Node:   slot_node[0]   = cfg_data;
          RegSlot1Node:   slot_node[1]   = cfg_data;
          RegSlot2Node:   slot_node[2]   = cfg_data;
          RegSlot0Layout: slot_layout[0] = cfg_data[0];
          RegSlot1Layout: slot_layout[1] = cfg_data[0];
          RegSlot2Layout: slot_layout[2] = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t unexpected update: slot %0d kind %0d value %h last %0b", $realtime,
                     out_item.target_slot, out_item.update_kind, out_item.update_value,
                     out_item.last_update);
          mismatch_count++;
        end else begin
          want = expected_updates.pop_front();
          if (out_item.target_slot !== want.target_slot ||
              out_item.update_kind !== want.update_kind ||
              out_item.update_value !== want.update_value ||
              out_item.last_update !== want.last_update) begin
            if (mismatch_count < 10)
              $display({"%0t update mismatch: exp slot %0d kind %0d value %h last %0b,",
                        " got slot %0d kind %0d value %h last %0b"},
                       $realtime, want.target_slot, want.update_kind, want.update_value,
                       want.last_update, out_item.target_slot, out_item.update_kind,
                       out_item.update_value, out_item.last_update);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_frame_updates(in_item);
    end
    updates_pending = expected_updates.size();
  end

endmodule

>>> test/tb_canopen_servo_rx_frame_decoder_top.sv
// Testbench top for canopen_servo_rx_frame_decoder_top: drives frames, output
// back-pressure and slot configuration; crxd_update_checker does the checking.
// Depends on crxd_pkg, crxd_update_checker and the block's RTL.
`timescale 1ns / 1ps

module tb_canopen_servo_rx_frame_decoder_top;
  import crxd_pkg::*;

  // well-formed random frames; bus noise and directed frames come on top
  localparam int ItemTarget  = 372;
  localparam int PhaseCount  = 6;
  localparam int PhaseItems  = ItemTarget / PhaseCount;
  localparam int StallLimit  = 5000;  // idle cycles with no transaction at all
  localparam int DrainCycles = 12;    // pipe is four deep; dropped frames leave no trace
  localparam int QuietPhase  = 3;     // this phase runs without any idling

  // indexes past the register file; writes there must be ignored
  localparam logic [2:0] RegUnusedLow  = 3'd6;
  localparam logic [2:0] RegUnusedHigh = 3'd7;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data  = '0;

  int mismatch_count;
  int updates_pending;
  int stall_cycles = 0;
  bit quiet        = 1'b0;

  // node ids as currently programmed, so random frames can hit real slots
  logic [6:0] cur_node [SlotCount] = '{7'd1, 7'd2, 7'd3};

  initial begin
    forever #5 clk = ~clk;
  end

  canopen_servo_rx_frame_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  crxd_update_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .updates_pending (updates_pending)
  );

  // Result side back-pressure: ~8% stall, none during the quiet phase.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 8);
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("FAIL canopen_servo_rx_frame_decoder_top");
      $finish;
    end
  end

  function automatic in_item_t frame(input logic [10:0] ident, input logic [63:0] payload,
                                     input logic [3:0] len);
    in_item_t f;
    f.frame_ident   = ident;
    f.frame_payload = payload;
    f.frame_length  = len;
    return f;
  endfunction

  // SDO upload response layout: command, index low/high, subindex, data bytes 4..7
  function automatic logic [63:0] sdo(input logic [7:0] cmd, input logic [15:0] obj,
                                      input logic [31:0] data);
    return {data, 8'($urandom), obj, cmd};
  endfunction

  // Mostly well-formed frames aimed at a programmed slot; ~15% raw bus noise,
  // which is not counted toward the item budget.
  function automatic in_item_t random_frame(output bit counted);
    in_item_t    f;
    int          slot;
    int          pick;
    logic [31:0] data;
    logic [7:0]  cmd;
    logic [15:0] obj;
    counted = 1'b1;
    if ($urandom_range(99) < 15) begin
      counted = 1'b0;
      return frame(11'($urandom), {$urandom, $urandom}, 4'($urandom));
    end
    slot = $urandom_range(SlotCount - 1);
    f.frame_ident = ($urandom_range(1) ? SdoRespBase : Tpdo1Base) + 11'(cur_node[slot]);
    case ($urandom_range(7))
      0:       data = 32'h0000_0000;
      1:       data = 32'hFFFF_FFFF;
      2:       data = 32'h8000_0000;
      3:       data = 32'h7FFF_FFFF;
      default: data = $urandom;
    endcase
    pick = $urandom_range(99);
    if (pick < 45) begin
      cmd = ($urandom_range(9) == 0) ? 8'($urandom) :
            ($urandom_range(1) ? SdoUp4Byte : SdoUp2Byte);
      case ($urandom_range(4))
        0:       obj = ObjSpeed;
        1:       obj = ObjPosition;
        2:       obj = ObjError;
        3:       obj = ObjStatus;
        default: obj = 16'($urandom);
      endcase
      f.frame_payload = sdo(cmd, obj, data);
      f.frame_length  = LenFull;
    end else if (pick < 70) begin
      // process-data style full frame
      f.frame_payload = {data, $urandom};
      f.frame_length  = LenFull;
    end else if (pick < 90) begin
      f.frame_payload = {16'($urandom), data, 16'($urandom)};
      f.frame_length  = LenShort;
    end else begin
      f.frame_payload = {$urandom, $urandom};
      f.frame_length  = 4'($urandom);
    end
    return f;
  endfunction

  // Offer one frame and hold it until taken. in_ready is sampled at the
  // falling edge: every input moves only at the rising edge, so that value
  // holds up to the edge that accepts. Valid is left high for back-to-back
  // frames; it only drops for a random one-cycle gap.
  task automatic send_frame(input in_item_t f);
    bit taken;
    in_item  <= f;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop sending until every predicted update is out, then let any dropped
  // frames clear the pipe so the block is idle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(negedge clk); while (updates_pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // All six registers back to back, then a write to an unused index.
  // Layout writes carry junk in the upper bits; only bit zero counts.
  task automatic load_slots(input logic [6:0] n0, input logic [6:0] n1, input logic [6:0] n2,
                            input logic l0, input logic l1, input logic l2);
    cfg_write(RegSlot0Node, n0);
    cfg_write(RegSlot1Node, n1);
    cfg_write(RegSlot2Node, n2);
    cfg_write(RegSlot0Layout, {6'($urandom), l0});
    cfg_write(RegSlot1Layout, {6'($urandom), l1});
    cfg_write(RegSlot2Layout, {6'($urandom), l2});
    cfg_write($urandom_range(1) ? RegUnusedLow : RegUnusedHigh, 7'($urandom));
    cfg_we      <= 1'b0;
    cur_node[0] = n0;
    cur_node[1] = n1;
    cur_node[2] = n2;
  endtask

  function automatic logic [6:0] random_node();
    return ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
  endfunction

  initial begin
    int         counted_items;
    bit         counted;
    logic [6:0] n0, n1, n2;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset configuration: nodes 1/2/3, slots 0-1 velocity, slot 2 slide.
    // SDO uploads: every object under each command that carries it, value extremes.
    send_frame(frame(11'h181, sdo(SdoUp4Byte, ObjSpeed, 32'h8000_0000), LenFull));
    send_frame(frame(11'h581, sdo(SdoUp4Byte, ObjPosition, 32'h7FFF_FFFF), LenFull));
    send_frame(frame(11'h581, sdo(SdoUp4Byte, ObjError, 32'h1234_FFFF), LenFull));
    send_frame(frame(11'h182, sdo(SdoUp2Byte, ObjStatus, 32'hFFFF_8001), LenFull));
    send_frame(frame(11'h582, sdo(SdoUp2Byte, ObjError, 32'h0000_0000), LenFull));
    // command and object that do not pair up, and an unknown command
    send_frame(frame(11'h181, sdo(SdoUp2Byte, ObjSpeed, 32'hFFFF_FFFF), LenFull));
    send_frame(frame(11'h181, sdo(SdoUp4Byte, ObjStatus, 32'hFFFF_FFFF), LenFull));
    send_frame(frame(11'h181, sdo(8'h40, ObjSpeed, 32'hFFFF_FFFF), LenFull));
    // short TPDO: status + speed, also on the SDO identifier
    send_frame(frame(11'h182, 64'hFFFF_FFFF_FFFF_FFFF, LenShort));
    send_frame(frame(11'h182, 64'h0000_0000_0000_0000, LenShort));
    send_frame(frame(11'h581, 64'hFFFF_8000_0000_1234, LenShort));
    // slide layout TPDO: negative and positive 16-bit speed
    send_frame(frame(11'h183, 64'h8000_0000_8000_ABCD, LenFull));
    send_frame(frame(11'h583, 64'h7FFF_FFFF_7FFF_0000, LenFull));
    // slide layout falls back to SDO decoding on an upload command
    send_frame(frame(11'h183, sdo(SdoUp4Byte, ObjPosition, 32'hDEAD_BEEF), LenFull));
    send_frame(frame(11'h583, sdo(SdoUp2Byte, ObjStatus, 32'h0000_FFFF), LenFull));
    send_frame(frame(11'h183, sdo(SdoUp4Byte, 16'h1000, 32'h1111_2222), LenFull));
    send_frame(frame(11'h183, 64'hFFFF_FFFF_FFFF_FFFF, LenShort));
    // lengths with no rule, up to the top code
    send_frame(frame(11'h181, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
    send_frame(frame(11'h181, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7));
    send_frame(frame(11'h181, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9));
    send_frame(frame(11'h181, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15));
    // identifiers that hit no slot
    send_frame(frame(11'h000, 64'h0000_0000_0000_0000, LenFull));
    send_frame(frame(11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, LenShort));
    send_frame(frame(11'h184, 64'h0123_4567_89AB_CDEF, LenShort));
    send_frame(frame(11'h580, 64'h0123_4567_89AB_CDEF, LenShort));

    // Phases: extremes first, then random slot maps. Each reconfig waits for
    // the block to go idle.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_pipeline();
      case (phase)
        0: load_slots(7'd127, 7'd1, 7'd64, 1'b1, 1'b1, 1'b0);
        1: begin
          // node id zero on two slots: 0x180/0x580 go to slot 0, never slot 1
          load_slots(7'd0, 7'd0, 7'd127, 1'b1, 1'b0, 1'b0);
          send_frame(frame(11'h180, 64'h8765_4321_FFFF_0001, LenFull));
          send_frame(frame(11'h580, 64'h8765_4321_FFFF_0001, LenShort));
          send_frame(frame(11'h5FF, 64'h0000_7FFF_FFFF_8000, LenShort));
        end
        default: begin
          n0 = random_node();
          n1 = $urandom_range(3) == 0 ? n0 : random_node();
          n2 = $urandom_range(3) == 0 ? n1 : random_node();
          load_slots(n0, n1, n2, 1'($urandom), 1'($urandom), 1'($urandom));
        end
      endcase
      quiet = (phase == QuietPhase);
      counted_items = 0;
      while (counted_items < PhaseItems) begin
        send_frame(random_frame(counted));
        if (counted) counted_items++;
      end
      quiet = 1'b0;
    end

    drain_pipeline();
    if (mismatch_count == 0 && updates_pending == 0) begin
      $display("PASS canopen_servo_rx_frame_decoder_top");
    end else begin
      $display("FAIL canopen_servo_rx_frame_decoder_top");
    end
    $finish;
  end

endmodule
